>>> sv/assert_macros.svh
// Assertion macros for the RTL of the tick block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/tlbi_pkg.sv
// Types and constants of the millisecond tick block.
package tlbi_pkg;

    localparam int unsigned CountWidth = 16;
    localparam int unsigned PowerWidth = 8;
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth = 16;

    localparam logic [CountWidth-1:0] CupMax = 16'hFFFF;
    localparam logic [PowerWidth-1:0] PowerMax = 8'hFF;

    localparam logic [CountWidth-1:0] MsWrapReset = 16'd1000;
    localparam logic [CountWidth-1:0] BlinkReset = 16'd499;
    localparam logic [PowerWidth-1:0] PresetReset = 8'd50;

    // configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_MS_WRAP_LIMIT = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_BLINK_ON_LIMIT = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_POWER_PRESET = 2'd2;

    // LED flag bit positions
    localparam int unsigned FLAG_RED_STEADY = 0;
    localparam int unsigned FLAG_RED_FLASH = 1;
    localparam int unsigned FLAG_GREEN_STEADY = 2;
    localparam int unsigned FLAG_GREEN_FLASH = 3;
    localparam int unsigned FLAG_BLUE_STEADY = 4;
    localparam int unsigned FLAG_BLUE_FLASH = 5;

    typedef struct packed {
        logic       one_cup_pin_n;
        logic       two_cup_pin_n;
        logic       power_pin_n;
        logic [5:0] led_flags;
        logic       clear_seconds;
        logic       clear_user_timer;
        logic       clear_one_cup;
        logic       clear_two_cup;
        logic       preset_power;
    } tlbi_in_t;

    typedef struct packed {
        logic                  red_led;
        logic                  green_led;
        logic                  blue_led;
        logic [CountWidth-1:0] one_cup_level;
        logic [CountWidth-1:0] two_cup_level;
        logic [PowerWidth-1:0] power_level;
        logic [CountWidth-1:0] seconds_now;
        logic [CountWidth-1:0] user_ms_now;
        logic [CountWidth-1:0] ms_now;
    } tlbi_out_t;

endpackage

>>> sv/tick_led_blink_button_integrator_top.sv
// Millisecond tick block: time counters, LED drive and button integrators.
// An accepted input word passes the input register, then the result register.
// Throughput: one word per cycle while the result side does not stall; these two
// registers part the channels, and the counters update in one pass between them.
// Reset (rst_n low, asynchronous): all counters clear, config takes its
// reset values (wrap 1000, blink 499, preset 50), both stages empty.
`include "assert_macros.svh"

module tick_led_blink_button_integrator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tlbi_pkg::tlbi_in_t                  in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tlbi_pkg::tlbi_out_t                 out_word,
    input  logic                                cfg_we,
    input  logic [tlbi_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [tlbi_pkg::CfgDataWidth-1:0]   cfg_data
);
    import tlbi_pkg::*;

    // configuration registers
    logic [CountWidth-1:0] ms_wrap_limit_reg;
    logic [CountWidth-1:0] blink_on_limit_reg;
    logic [PowerWidth-1:0] power_preset_reg;

    // tick state
    logic [CountWidth-1:0] ms_count_reg, ms_count_next;
    logic [CountWidth-1:0] sec_count_reg, sec_count_next;
    logic [CountWidth-1:0] user_ms_reg, user_ms_next;
    logic [CountWidth-1:0] one_cup_reg, one_cup_next;
    logic [CountWidth-1:0] two_cup_reg, two_cup_next;
    logic [PowerWidth-1:0] power_reg, power_next;

    // input stage and result stage
    logic      s1_valid_reg;
    tlbi_in_t  s1_word_reg;
    logic      out_valid_reg;
    tlbi_out_t out_word_reg;
    tlbi_out_t out_word_next;

    logic advance;

    // pre-tick values after the clear and preset requests
    logic [CountWidth-1:0] ms_pre, sec_pre, user_pre, one_pre, two_pre;
    logic [PowerWidth-1:0] power_pre;
    logic                  blink_phase;

    // Move the held word into the result register when that slot is free.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    // Stall only when the input register is full and cannot drain.
    assign in_stall  = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        // apply requests before the tick
        ms_pre    = s1_word_reg.clear_seconds    ? '0 : ms_count_reg;
        sec_pre   = s1_word_reg.clear_seconds    ? '0 : sec_count_reg;
        user_pre  = s1_word_reg.clear_user_timer ? '0 : user_ms_reg;
        one_pre   = s1_word_reg.clear_one_cup    ? '0 : one_cup_reg;
        two_pre   = s1_word_reg.clear_two_cup    ? '0 : two_cup_reg;
        power_pre = s1_word_reg.preset_power     ? power_preset_reg : power_reg;

        // millisecond counter wraps once it reaches the limit, bumping seconds
        if (ms_pre < ms_wrap_limit_reg)
        begin
            ms_count_next  = ms_pre + 16'd1;
            sec_count_next = sec_pre;
        end
        else
        begin
            ms_count_next  = '0;
            sec_count_next = sec_pre + 16'd1;
        end
        user_ms_next = user_pre + 16'd1;

        // integrators: count up while pressed (pin low), down while released
        if (!s1_word_reg.one_cup_pin_n)
            one_cup_next = (one_pre == CupMax) ? one_pre : one_pre + 16'd1;
        else
            one_cup_next = (one_pre == '0) ? one_pre : one_pre - 16'd1;

        if (!s1_word_reg.two_cup_pin_n)
            two_cup_next = (two_pre == CupMax) ? two_pre : two_pre + 16'd1;
        else
            two_cup_next = (two_pre == '0) ? two_pre : two_pre - 16'd1;

        if (!s1_word_reg.power_pin_n)
            power_next = (power_pre == PowerMax) ? power_pre : power_pre + 8'd1;
        else
            power_next = (power_pre == '0) ? power_pre : power_pre - 8'd1;

        // blink phase uses the updated millisecond count
        blink_phase = ms_count_next < blink_on_limit_reg;

        out_word_next.red_led   = s1_word_reg.led_flags[FLAG_RED_STEADY]
            || (s1_word_reg.led_flags[FLAG_RED_FLASH] && blink_phase);
        out_word_next.green_led = s1_word_reg.led_flags[FLAG_GREEN_STEADY]
            || (s1_word_reg.led_flags[FLAG_GREEN_FLASH] && blink_phase);
        out_word_next.blue_led  = s1_word_reg.led_flags[FLAG_BLUE_STEADY]
            || (s1_word_reg.led_flags[FLAG_BLUE_FLASH] && blink_phase);
        out_word_next.one_cup_level = one_cup_next;
        out_word_next.two_cup_level = two_cup_next;
        out_word_next.power_level   = power_next;
        out_word_next.seconds_now   = sec_count_next;
        out_word_next.user_ms_now   = user_ms_next;
        out_word_next.ms_now        = ms_count_next;
    end

    // Control state, counters and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            ms_wrap_limit_reg  <= MsWrapReset;
            blink_on_limit_reg <= BlinkReset;
            power_preset_reg   <= PresetReset;
            ms_count_reg       <= '0;
            sec_count_reg      <= '0;
            user_ms_reg        <= '0;
            one_cup_reg        <= '0;
            two_cup_reg        <= '0;
            power_reg          <= '0;
        end
        else
        begin
            // load a new word whenever the input register is empty or draining
            if (!in_stall)
                s1_valid_reg <= in_valid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                ms_count_reg  <= ms_count_next;
                sec_count_reg <= sec_count_next;
                user_ms_reg   <= user_ms_next;
                one_cup_reg   <= one_cup_next;
                two_cup_reg   <= two_cup_next;
                power_reg     <= power_next;
            end

            // unknown indexes drop the write
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MS_WRAP_LIMIT:  ms_wrap_limit_reg  <= cfg_data;
                    CFG_BLINK_ON_LIMIT: blink_on_limit_reg <= cfg_data;
                    CFG_POWER_PRESET:   power_preset_reg   <= cfg_data[PowerWidth-1:0];
                    default:            ;
                endcase
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_word_reg <= in_word;
        if (advance)
            out_word_reg <= out_word_next;
    end

    // A stall on input means both stages are full and the output is held.
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall,
        s1_valid_reg && out_valid_reg && out_stall)
    // A word moved on always shows up as a valid result next cycle.
    `ASSERT_NEXT(a_advance_out, clk, rst_n, advance, out_valid_reg)
    // A shown result agrees with the counters it was taken from.
    `ASSERT_IMPLIES(a_out_state, clk, rst_n, out_valid_reg,
        out_word_reg.seconds_now == sec_count_reg && out_word_reg.ms_now == ms_count_reg)
    // Power integrator steps up by one while pressed below saturation.
    `ASSERT_NEXT(a_power_up, clk, rst_n,
        advance && !s1_word_reg.power_pin_n && !s1_word_reg.preset_power
            && power_reg != PowerMax,
        power_reg == $past(power_reg) + 8'd1)

endmodule

>>> dv/tb_tick_led_blink_button_integrator_top.sv
// Self-checking testbench for the millisecond tick block: directed table, then random phases.
`timescale 1ns / 100ps

module tb_tick_led_blink_button_integrator_top;
    import tlbi_pkg::*;

    // Index that decodes to no register; a write to it must change nothing.
    localparam logic [CfgIndexWidth-1:0] CFG_NO_REGISTER = 2'd3;

    localparam int unsigned NumDirected   = 18;
    localparam int unsigned SoakTicks     = 300;
    localparam int unsigned HoldOffCycles = 150;
    localparam int unsigned WatchdogLimit = 2000;
    // Result register sits behind the input register.
    localparam int unsigned SettleCycles  = 4;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    tlbi_in_t  in_word;
    logic      out_valid;
    logic      out_stall;
    tlbi_out_t out_word;
    logic      cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;

    tick_led_blink_button_integrator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block's registers and counters, kept by the predictor.
    logic [CountWidth-1:0] wrap_limit;
    logic [CountWidth-1:0] blink_limit;
    logic [PowerWidth-1:0] preset_val;
    logic [CountWidth-1:0] ms_cnt;
    logic [CountWidth-1:0] sec_cnt;
    logic [CountWidth-1:0] user_cnt;
    logic [CountWidth-1:0] one_cup_int;
    logic [CountWidth-1:0] two_cup_int;
    logic [PowerWidth-1:0] power_int;

    tlbi_out_t   pending_results[$];
    int unsigned ticks_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned settings_loaded;
    bit          steady_run;  // no idling on either side while set
    bit          hold_req;    // ask the result side for one long hold-off

    // Directed table. Tick columns: pins {one, two, power} (0 = pressed),
    // led flags [5:0], requests {clr_sec, clr_user, clr_one, clr_two, preset}.
    // Result column: {leds rgb, one, two, power, seconds, user ms, ms}.
    typedef struct {
        tlbi_in_t  tick;
        bit        typed;
        tlbi_out_t want;
    } dir_row_t;

    dir_row_t directed_rows [NumDirected] = '{
        // all released straight out of reset: integrators stay pinned at zero
        '{{3'b111, 6'b000000, 5'b00000}, 1'b1,
          {3'b000, 16'd0, 16'd0, 8'd0, 16'd0, 16'd1, 16'd1}},
        // every on-flag, every button pressed
        '{{3'b000, 6'b010101, 5'b00000}, 1'b1,
          {3'b111, 16'd1, 16'd1, 8'd1, 16'd0, 16'd2, 16'd2}},
        // every blink-flag, early in the second so blinking LEDs are lit
        '{{3'b000, 6'b101010, 5'b00000}, 1'b1,
          {3'b111, 16'd2, 16'd2, 8'd2, 16'd0, 16'd3, 16'd3}},
        '{{3'b011, 6'b000001, 5'b00000}, 1'b0, '0},
        '{{3'b101, 6'b000100, 5'b00000}, 1'b0, '0},
        '{{3'b110, 6'b010000, 5'b00000}, 1'b0, '0},
        '{{3'b111, 6'b000010, 5'b00000}, 1'b0, '0},
        '{{3'b111, 6'b001000, 5'b00000}, 1'b0, '0},
        '{{3'b111, 6'b100000, 5'b00000}, 1'b0, '0},
        '{{3'b000, 6'b111111, 5'b00001}, 1'b0, '0},
        '{{3'b000, 6'b011011, 5'b00100}, 1'b0, '0},
        '{{3'b000, 6'b110110, 5'b00010}, 1'b0, '0},
        '{{3'b010, 6'b000000, 5'b01000}, 1'b0, '0},
        '{{3'b101, 6'b101101, 5'b10000}, 1'b0, '0},
        // every clear plus the preset, buttons pressed: preset 50 then up one
        '{{3'b000, 6'b111111, 5'b11111}, 1'b1,
          {3'b111, 16'd1, 16'd1, 8'd51, 16'd0, 16'd1, 16'd1}},
        // same requests, buttons released: cups clamp at zero, power down one
        '{{3'b111, 6'b000000, 5'b11111}, 1'b1,
          {3'b000, 16'd0, 16'd0, 8'd49, 16'd0, 16'd1, 16'd1}},
        '{{3'b100, 6'b111111, 5'b10001}, 1'b0, '0},
        '{{3'b001, 6'b100011, 5'b01110}, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [CountWidth-1:0] cup_step(input logic [CountWidth-1:0] lvl,
                                                       input logic pin_n);
        if (!pin_n)
            return (lvl == CupMax) ? lvl : lvl + 1'b1;
        return (lvl == '0) ? lvl : lvl - 1'b1;
    endfunction

    function automatic logic led_lit(input logic [5:0] flags, input int unsigned on_bit,
                                     input logic phase);
        return flags[on_bit] || (flags[on_bit + 1] && phase);
    endfunction

    // Apply one tick to the mirrored counters and return the result word it gives.
    function automatic tlbi_out_t advance_tick(input tlbi_in_t w);
        tlbi_out_t r;
        logic      lit_phase;
        // requests land before the tick update
        if (w.clear_seconds)
        begin
            ms_cnt  = '0;
            sec_cnt = '0;
        end
        if (w.clear_user_timer)
            user_cnt = '0;
        if (w.clear_one_cup)
            one_cup_int = '0;
        if (w.clear_two_cup)
            two_cup_int = '0;
        if (w.preset_power)
            power_int = preset_val;

        // a count at or past the limit wraps, even when the limit just dropped below it
        if (ms_cnt < wrap_limit)
            ms_cnt = ms_cnt + 1'b1;
        else
        begin
            ms_cnt  = '0;
            sec_cnt = sec_cnt + 1'b1;
        end
        user_cnt  = user_cnt + 1'b1;
        lit_phase = ms_cnt < blink_limit;

        one_cup_int = cup_step(one_cup_int, w.one_cup_pin_n);
        two_cup_int = cup_step(two_cup_int, w.two_cup_pin_n);
        if (!w.power_pin_n)
        begin
            if (power_int != PowerMax)
                power_int = power_int + 1'b1;
        end
        else if (power_int != '0)
            power_int = power_int - 1'b1;

        r.red_led       = led_lit(w.led_flags, FLAG_RED_STEADY, lit_phase);
        r.green_led     = led_lit(w.led_flags, FLAG_GREEN_STEADY, lit_phase);
        r.blue_led      = led_lit(w.led_flags, FLAG_BLUE_STEADY, lit_phase);
        r.one_cup_level = one_cup_int;
        r.two_cup_level = two_cup_int;
        r.power_level   = power_int;
        r.seconds_now   = sec_cnt;
        r.user_ms_now   = user_cnt;
        r.ms_now        = ms_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, result side and watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: stall now and then, or hold off for a long stretch on request.
    initial
    begin : result_sink
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HoldOffCycles) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= !steady_run && ($urandom_range(0, 99) < 6);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare every accepted result word with the oldest pending prediction.
    always @(posedge clk)
    begin : result_check
        tlbi_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word arrived with nothing pending");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("red_led", want.red_led, out_word.red_led);
                check_field("green_led", want.green_led, out_word.green_led);
                check_field("blue_led", want.blue_led, out_word.blue_led);
                check_field("one_cup_level", want.one_cup_level, out_word.one_cup_level);
                check_field("two_cup_level", want.two_cup_level, out_word.two_cup_level);
                check_field("power_level", want.power_level, out_word.power_level);
                check_field("seconds_now", want.seconds_now, out_word.seconds_now);
                check_field("user_ms_now", want.user_ms_now, out_word.user_ms_now);
                check_field("ms_now", want.ms_now, out_word.ms_now);
            end
        end
    end

    // Count cycles with no handshake on either side; give up at the limit.
    initial
    begin : watchdog
        int unsigned dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < WatchdogLimit)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $error("no word moved for %0d cycles", WatchdogLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus tasks; each one starts and ends on a falling edge
    // ------------------------------------------------------------------

    // Offer one tick word, idling first at random; predict once it is taken.
    task automatic send_tick(input tlbi_in_t w, input bit typed, input tlbi_out_t want);
        tlbi_out_t predicted;
        while (!steady_run && ($urandom_range(0, 99) < 6))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        predicted = advance_tick(w);
        pending_results.push_back(typed ? want : predicted);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every pending result, then let the pipe settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MS_WRAP_LIMIT:  wrap_limit  = val;
            CFG_BLINK_ON_LIMIT: blink_limit = val;
            CFG_POWER_PRESET:   preset_val  = val[PowerWidth-1:0];
            default: ;  // no register behind this index
        endcase
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [CountWidth-1:0] wrap,
                                 input logic [CountWidth-1:0] blink,
                                 input logic [PowerWidth-1:0] preset);
        wait_drained();
        write_reg(CFG_MS_WRAP_LIMIT, wrap);
        write_reg(CFG_BLINK_ON_LIMIT, blink);
        write_reg(CFG_POWER_PRESET, CfgDataWidth'(preset));
        settings_loaded++;
    endtask

    // Random ticks: each button pressed with the given chance in percent, each
    // request raised about once in req_odds ticks (never when req_odds is zero).
    task automatic run_random(input int unsigned count, input int unsigned press_pct,
                              input int unsigned req_odds);
        tlbi_in_t w;
        repeat (count)
        begin
            w.one_cup_pin_n    = $urandom_range(0, 99) >= press_pct;
            w.two_cup_pin_n    = $urandom_range(0, 99) >= press_pct;
            w.power_pin_n      = $urandom_range(0, 99) >= press_pct;
            w.led_flags        = 6'($urandom_range(0, 63));
            w.clear_seconds    = (req_odds != 0) && ($urandom_range(1, req_odds) == 1);
            w.clear_user_timer = (req_odds != 0) && ($urandom_range(1, req_odds) == 1);
            w.clear_one_cup    = (req_odds != 0) && ($urandom_range(1, req_odds) == 1);
            w.clear_two_cup    = (req_odds != 0) && ($urandom_range(1, req_odds) == 1);
            w.preset_power     = (req_odds != 0) && ($urandom_range(1, req_odds) == 1);
            send_tick(w, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        // drive every input to a known level from time zero
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // mirror the block's reset state
        wrap_limit      = MsWrapReset;
        blink_limit     = BlinkReset;
        preset_val      = PresetReset;
        ms_cnt          = '0;
        sec_cnt         = '0;
        user_cnt        = '0;
        one_cup_int     = '0;
        two_cup_int     = '0;
        power_int       = '0;
        ticks_sent      = 0;
        results_seen    = 0;
        mismatches      = 0;
        settings_loaded = 1;
        steady_run      = 1'b0;
        hold_req        = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table under reset settings.
        for (int i = 0; i < NumDirected; i++)
            send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);

        // Short second with a blink window of three: LEDs flicker every few ticks,
        // presets load the power ceiling. Then poke an index with no register.
        load_settings(16'd7, 16'd3, PowerMax);
        write_reg(CFG_NO_REGISTER, 16'hFFFF);
        run_random(300, 50, 16);

        // Widest limits, no requests and no idling: the millisecond count climbs
        // far past what the next setting allows.
        load_settings(CupMax, CupMax, 8'd0);
        steady_run = 1'b1;
        run_random(400, 50, 0);
        steady_run = 1'b0;

        // Limit of one: the first tick finds the count above it and wraps.
        load_settings(16'd1, 16'd0, 8'd128);
        run_random(200, 30, 16);

        // Zero limit bumps seconds on every tick. Hold every button down long
        // enough to pin the power integrator at its ceiling.
        load_settings(16'd0, 16'd1, PowerMax);
        run_random(SoakTicks, 100, 0);
        run_random(100, 50, 8);

        // Back to reset values for the pressure part.
        load_settings(MsWrapReset, BlinkReset, PresetReset);
        run_random(300, 60, 300);
        // hold off the result side while ticks keep coming, so the block backs up
        hold_req = 1'b1;
        run_random(400, 60, 300);
        // pause the tick side until every result is home
        wait_drained();
        run_random(300, 60, 300);

        wait_drained();
        repeat (2 * SettleCycles) @(negedge clk);

        $display("Ran %0d ticks over %0d register settings, incl. a %0d-tick soak at the limits.",
                 ticks_sent, settings_loaded, SoakTicks);
        $display("Compared %0d result words; %0d field mismatches.", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
